// ----- rtl/wsdf_pkg.sv -----
// ----------------------------------------------------------------------------
// WebSocket deframer package
// Result kinds, opcodes and widths shared by the deframer.
// ----------------------------------------------------------------------------
package wsdf_pkg;

  localparam int unsigned LenW = 32;
  localparam logic [LenW-1:0] MaxPayloadReset = 32'd65534;

  typedef enum logic [2:0] {
    KIND_BYTE  = 3'd0,
    KIND_EMPTY = 3'd1,
    KIND_PING  = 3'd2,
    KIND_CLOSE = 3'd3,
    KIND_ERROR = 3'd4
  } kind_t;

  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] KEY_BYTES   = 4'd4;

endpackage

// ----- rtl/websocket_frame_deframer.sv -----
// ----------------------------------------------------------------------------
// WebSocket frame deframer
// Parses received frame headers, unmasks and forwards data payload bytes.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries the received byte stream, one byte per beat in s_tdata.
//   m_* carries one result beat per reported event: m_tuser is the kind
//   (payload byte, empty data frame, ping seen, close, error), m_tdata holds
//   the payload byte, opcode and fin bit, m_tlast marks the end of a frame.
//   Header and skipped payload bytes produce no output beat unless they end an event.
//   cfg_wr_en/cfg_wr_data write the largest accepted payload length; write
//   only while the stream is idle.
//   The result beat is registered and appears in the cycle after its input
//   beat is accepted. One byte is taken every cycle; the single output
//   register is the only storage between the two sides, so a byte is accepted
//   whenever that register is empty or is being drained in the same cycle. A
//   stalled receiver holds the result and back-pressures the input.
//   A close frame or an oversize length halts parsing: further bytes are
//   accepted and dropped until reset. Reset returns the parser to the first
//   header byte and the length limit to 65534.
// ----------------------------------------------------------------------------
module websocket_frame_deframer (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,   // max_payload_len
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,       // data_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,       // [7:0] payload_byte, [11:8] opcode, [12] fin, zero pad
  output logic [2:0]  m_tuser,       // kind
  output logic        m_tlast        // last_of_frame
);

  typedef enum logic [2:0] {
    PH_HEAD0,
    PH_HEAD1,
    PH_EXTLEN,
    PH_MASK,
    PH_BODY,
    PH_HALT
  } phase_t;

  localparam int unsigned LenW = wsdf_pkg::LenW;

  phase_t                  phase, phase_next;
  logic [3:0]              header_count, header_count_next;
  logic [3:0]              frame_opcode, frame_opcode_next;
  logic                    frame_fin, frame_fin_next;
  logic                    mask_flag, mask_flag_next;
  logic [LenW-1:0]         payload_length, payload_length_next;
  logic                    length_high, length_high_next;
  logic [31:0]             mask_key, mask_key_next;
  logic [LenW-1:0]         remaining, remaining_next;
  logic [1:0]              key_idx, key_idx_next;
  logic [LenW-1:0]         max_payload_len;

  logic                    accept;
  logic                    emit;
  wsdf_pkg::kind_t         emit_kind;
  logic [7:0]              emit_byte;
  logic                    emit_last;
  logic                    len_done;
  logic                    body_start;
  logic                    is_data;
  logic [7:0]              key_byte;

  logic [7:0]              out_byte;
  logic [3:0]              out_opcode;
  logic                    out_fin;
  wsdf_pkg::kind_t         out_kind;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    phase_next          = phase;
    header_count_next   = header_count;
    frame_opcode_next   = frame_opcode;
    frame_fin_next      = frame_fin;
    mask_flag_next      = mask_flag;
    payload_length_next = payload_length;
    length_high_next    = length_high;
    mask_key_next       = mask_key;
    remaining_next      = remaining;
    key_idx_next        = key_idx;
    emit                = 1'b0;
    emit_kind           = wsdf_pkg::KIND_BYTE;
    emit_byte           = 8'd0;
    emit_last           = 1'b0;
    len_done            = 1'b0;
    body_start          = 1'b0;
    key_byte            = 8'd0;

    unique case (phase)
      PH_HEAD0: begin
        frame_fin_next    = s_tdata[7];
        frame_opcode_next = s_tdata[3:0];
        if (s_tdata[3:0] == wsdf_pkg::OP_CLOSE) begin
          phase_next = PH_HALT;
          emit       = 1'b1;
          emit_kind  = wsdf_pkg::KIND_CLOSE;
        end else begin
          phase_next = PH_HEAD1;
        end
      end
      PH_HEAD1: begin
        mask_flag_next   = s_tdata[7];
        length_high_next = 1'b0;
        if (s_tdata[6:0] == wsdf_pkg::LEN_EXT16 || s_tdata[6:0] == wsdf_pkg::LEN_EXT64) begin
          payload_length_next = '0;
          header_count_next   = (s_tdata[6:0] == wsdf_pkg::LEN_EXT16) ?
                                wsdf_pkg::EXT16_BYTES : wsdf_pkg::EXT64_BYTES;
          phase_next          = PH_EXTLEN;
        end else begin
          payload_length_next = LenW'(s_tdata[6:0]);
          len_done            = 1'b1;
        end
      end
      PH_EXTLEN: begin
        payload_length_next = {payload_length[LenW-9:0], s_tdata};
        length_high_next    = length_high || (payload_length[LenW-1:LenW-8] != 8'd0);
        header_count_next   = header_count - 4'd1;
        if (header_count == 4'd1) begin
          len_done = 1'b1;
        end
      end
      PH_MASK: begin
        mask_key_next     = {mask_key[23:0], s_tdata};
        header_count_next = header_count - 4'd1;
        if (header_count == 4'd1) begin
          body_start = 1'b1;
        end
      end
      PH_BODY: begin
        if (mask_flag) begin
          case (key_idx)
            2'd0:    key_byte = mask_key[31:24];
            2'd1:    key_byte = mask_key[23:16];
            2'd2:    key_byte = mask_key[15:8];
            default: key_byte = mask_key[7:0];
          endcase
        end
        key_idx_next   = key_idx + 2'd1;
        remaining_next = remaining - LenW'(1);
        emit_last      = (remaining == LenW'(1));
        if (emit_last) begin
          phase_next = PH_HEAD0;
        end
        if (frame_opcode <= wsdf_pkg::OP_BINARY) begin
          emit      = 1'b1;
          emit_kind = wsdf_pkg::KIND_BYTE;
          emit_byte = s_tdata ^ key_byte;
        end else if (frame_opcode == wsdf_pkg::OP_PING && emit_last) begin
          emit      = 1'b1;
          emit_kind = wsdf_pkg::KIND_PING;
        end
      end
      default: begin
        phase_next = PH_HALT;
      end
    endcase

    if (len_done) begin
      if (length_high_next || (payload_length_next > max_payload_len)) begin
        phase_next = PH_HALT;
        emit       = 1'b1;
        emit_kind  = wsdf_pkg::KIND_ERROR;
      end else if (mask_flag_next) begin
        mask_key_next     = '0;
        header_count_next = wsdf_pkg::KEY_BYTES;
        phase_next        = PH_MASK;
      end else begin
        body_start = 1'b1;
      end
    end

    is_data = (frame_opcode_next <= wsdf_pkg::OP_BINARY);
    if (body_start) begin
      if (payload_length_next == '0) begin
        phase_next = PH_HEAD0;
        if (is_data) begin
          emit      = 1'b1;
          emit_kind = wsdf_pkg::KIND_EMPTY;
          emit_last = 1'b1;
        end else if (frame_opcode_next == wsdf_pkg::OP_PING) begin
          emit      = 1'b1;
          emit_kind = wsdf_pkg::KIND_PING;
          emit_last = 1'b1;
        end
      end else begin
        remaining_next = payload_length_next;
        key_idx_next   = 2'd0;
        phase_next     = PH_BODY;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HEAD0;
      header_count    <= '0;
      frame_opcode    <= '0;
      frame_fin       <= 1'b0;
      mask_flag       <= 1'b0;
      payload_length  <= '0;
      length_high     <= 1'b0;
      mask_key        <= '0;
      remaining       <= '0;
      key_idx         <= '0;
      max_payload_len <= wsdf_pkg::MaxPayloadReset;
      m_tvalid        <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_payload_len <= cfg_wr_data;
      end
      if (accept) begin
        phase          <= phase_next;
        header_count   <= header_count_next;
        frame_opcode   <= frame_opcode_next;
        frame_fin      <= frame_fin_next;
        mask_flag      <= mask_flag_next;
        payload_length <= payload_length_next;
        length_high    <= length_high_next;
        mask_key       <= mask_key_next;
        remaining      <= remaining_next;
        key_idx        <= key_idx_next;
        m_tvalid       <= emit;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_byte   <= emit_byte;
      out_opcode <= frame_opcode_next;
      out_fin    <= frame_fin_next;
      out_kind   <= emit_kind;
      m_tlast    <= emit_last;
    end
  end

  assign m_tdata = {3'b000, out_fin, out_opcode, out_byte};
  assign m_tuser = out_kind;

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket deframer testbench
// Feeds whole frames (every opcode, 7/16/64-bit lengths, masked and unmasked)
// through the byte stream under random sender bursts and receiver stalls. A
// local parser predicts each result beat. The length limit is changed between
// phases. The run ends on a close frame or an oversize length.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [3:0] OP_CONT = 4'h0;
  localparam logic [3:0] OP_TEXT = 4'h1;
  localparam logic [3:0] OP_PONG = 4'hA;
  localparam int unsigned TargetBytes = 1700;

  typedef enum logic [2:0] {
    P_HDR0, P_HDR1, P_EXTLEN, P_KEY, P_BODY, P_HALT
  } parse_t;

  typedef struct packed {
    wsdf_pkg::kind_t kind;
    logic [7:0]      pbyte;
    logic [3:0]      op;
    logic            fin;
    logic            last;
  } deframed_t;

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [31:0] cfg_wr_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;    // data_byte
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;    // [7:0] payload_byte, [11:8] opcode, [12] fin, zero pad
  logic [2:0]  m_tuser;    // kind
  logic        m_tlast;    // last_of_frame

  websocket_frame_deframer i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // stream bytes waiting to be sent, and result beats still owed
  logic [7:0]  stream_q[$];
  deframed_t   owed_q[$];
  int unsigned bytes_queued = 0;
  int unsigned fails = 0;

  // parser state of the prediction
  parse_t      pst;
  logic [3:0]  hdr_left;
  logic [3:0]  cur_op;
  logic        cur_fin;
  logic        masked;
  logic [63:0] frame_len;
  logic [31:0] key;
  logic [63:0] taken;
  logic [31:0] len_limit;

  task automatic owe(input wsdf_pkg::kind_t k, input logic [7:0] b, input logic lst);
    deframed_t r;
    r.kind  = k;
    r.pbyte = b;
    r.op    = cur_op;
    r.fin   = cur_fin;
    r.last  = lst;
    owed_q.push_back(r);
  endtask

  task automatic open_body();
    if (frame_len == 64'd0) begin
      pst = P_HDR0;
      if (cur_op <= wsdf_pkg::OP_BINARY) owe(wsdf_pkg::KIND_EMPTY, 8'd0, 1'b1);
      else if (cur_op == wsdf_pkg::OP_PING) owe(wsdf_pkg::KIND_PING, 8'd0, 1'b1);
    end else begin
      taken = 64'd0;
      pst   = P_BODY;
    end
  endtask

  task automatic length_known();
    if (frame_len > {32'd0, len_limit}) begin
      pst = P_HALT;
      owe(wsdf_pkg::KIND_ERROR, 8'd0, 1'b0);
    end else if (masked) begin
      key      = 32'd0;
      hdr_left = wsdf_pkg::KEY_BYTES;
      pst      = P_KEY;
    end else begin
      open_body();
    end
  endtask

  task automatic deframe_byte(input logic [7:0] b);
    logic [7:0] kb;
    logic       lst;
    case (pst)
      P_HDR0: begin
        cur_fin = b[7];
        cur_op  = b[3:0];
        if (cur_op == wsdf_pkg::OP_CLOSE) begin
          pst = P_HALT;
          owe(wsdf_pkg::KIND_CLOSE, 8'd0, 1'b0);
        end else begin
          pst = P_HDR1;
        end
      end
      P_HDR1: begin
        masked    = b[7];
        frame_len = 64'd0;
        if (b[6:0] == wsdf_pkg::LEN_EXT16 || b[6:0] == wsdf_pkg::LEN_EXT64) begin
          hdr_left = (b[6:0] == wsdf_pkg::LEN_EXT16) ? wsdf_pkg::EXT16_BYTES
                                                     : wsdf_pkg::EXT64_BYTES;
          pst      = P_EXTLEN;
        end else begin
          frame_len = 64'(b[6:0]);
          length_known();
        end
      end
      P_EXTLEN: begin
        frame_len = {frame_len[55:0], b};
        hdr_left  = hdr_left - 4'd1;
        if (hdr_left == 4'd0) length_known();
      end
      P_KEY: begin
        key      = {key[23:0], b};
        hdr_left = hdr_left - 4'd1;
        if (hdr_left == 4'd0) open_body();
      end
      P_BODY: begin
        kb    = masked ? 8'(key >> (8 * (3 - taken[1:0]))) : 8'd0;
        taken = taken + 64'd1;
        lst   = (taken >= frame_len);
        if (lst) pst = P_HDR0;
        if (cur_op <= wsdf_pkg::OP_BINARY) owe(wsdf_pkg::KIND_BYTE, b ^ kb, lst);
        else if (cur_op == wsdf_pkg::OP_PING && lst) owe(wsdf_pkg::KIND_PING, 8'd0, 1'b1);
      end
      default: ;
    endcase
  endtask

  // driver: bursts of random length with random gaps
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;

  always @(posedge clk) begin
    logic       nv;
    logic [7:0] nd;
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 8'd0;
    end else begin
      nv = s_tvalid;
      nd = s_tdata;
      if (s_tvalid && s_tready) begin
        deframe_byte(s_tdata);
        nv = 1'b0;
      end
      if (!nv) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (stream_q.size() != 0) begin
          nd = stream_q.pop_front();
          nv = 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
      s_tvalid <= nv;
      s_tdata  <= nd;
    end
  end

  // receiver: stall pattern reloaded when the position counter wraps, sometimes never stalling
  logic [15:0] rdy_pat = 16'hFFFF;
  logic [3:0]  rdy_pos = 4'd0;

  always @(posedge clk) begin
    if (rdy_pos == 4'd15)
      rdy_pat <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
    rdy_pos  <= rdy_pos + 4'd1;
    m_tready <= rdy_pat[rdy_pos];
  end

  // monitor
  always @(posedge clk) begin
    deframed_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (owed_q.size() == 0) begin
        fails++;
        if (fails <= 10)
          $display("unexpected beat: kind %0d data %h last %b", m_tuser, m_tdata, m_tlast);
      end else begin
        want = owed_q.pop_front();
        if (m_tuser != want.kind || m_tdata != {3'd0, want.fin, want.op, want.pbyte} ||
            m_tlast != want.last) begin
          fails++;
          if (fails <= 10)
            $display("beat mismatch: kind %0d/%0d byte %h/%h op %h/%h fin %b/%b last %b/%b",
                     want.kind, m_tuser, want.pbyte, m_tdata[7:0], want.op, m_tdata[11:8],
                     want.fin, m_tdata[12], want.last, m_tlast);
        end
      end
    end
  end

  task automatic push_byte(input logic [7:0] b);
    stream_q.push_back(b);
    bytes_queued++;
  endtask

  task automatic put_header(input logic [3:0] op, input logic fin, input logic [63:0] len,
                            input int form, input logic msk);
    push_byte({fin, 3'($urandom), op});
    case (form)
      0: push_byte({msk, len[6:0]});
      1: begin
        push_byte({msk, wsdf_pkg::LEN_EXT16});
        for (int i = 1; i >= 0; i--) push_byte(len[8*i +: 8]);
      end
      default: begin
        push_byte({msk, wsdf_pkg::LEN_EXT64});
        for (int i = 7; i >= 0; i--) push_byte(len[8*i +: 8]);
      end
    endcase
    if (msk)
      for (int i = 0; i < 4; i++) push_byte(8'($urandom));
  endtask

  task automatic put_frame(input logic [3:0] op, input logic fin, input logic [63:0] len,
                           input int form, input logic msk);
    put_header(op, fin, len, form, msk);
    for (longint i = 0; i < longint'(len); i++) push_byte(8'($urandom));
  endtask

  function automatic logic [63:0] pick_len();
    int unsigned r;
    logic [63:0] l;
    r = $urandom_range(0, 19);
    if (r < 12) l = 64'($urandom_range(0, 12));
    else if (r < 15) l = 64'($urandom_range(13, 125));
    else if (r < 17) l = 64'($urandom_range(126, 300));
    else if (r < 18) l = 64'd125;
    else l = (len_limit <= 300) ? 64'(len_limit) : 64'd0;
    if (l > {32'd0, len_limit}) l = 64'($urandom_range(0, len_limit));
    return l;
  endfunction

  function automatic int pick_form(input logic [63:0] l);
    int unsigned r;
    r = $urandom_range(0, 5);
    if (l > 64'd65535) return 2;
    if (l <= 64'd125) return (r < 4) ? 0 : ((r == 4) ? 1 : 2);
    return (r < 4) ? 1 : 2;
  endfunction

  function automatic logic [3:0] pick_op();
    int unsigned r;
    logic [3:0]  op;
    r = $urandom_range(0, 9);
    if (r < 6) return 4'($urandom_range(0, 2));
    if (r < 8) return wsdf_pkg::OP_PING;
    do op = 4'($urandom_range(0, 15)); while (op == wsdf_pkg::OP_CLOSE);
    return op;
  endfunction

  task automatic wait_idle();
    while (stream_q.size() != 0 || s_tvalid || owed_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_limit(input logic [31:0] v);
    wait_idle();
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    len_limit = v;
  endtask

  initial begin
    logic [63:0] l;
    int unsigned r;
    rst         = 1'b1;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = 32'd0;
    s_tvalid    = 1'b0;
    s_tdata     = 8'd0;
    m_tready    = 1'b0;
    pst         = P_HDR0;
    hdr_left    = 4'd0;
    cur_op      = 4'd0;
    cur_fin     = 1'b0;
    masked      = 1'b0;
    frame_len   = 64'd0;
    key         = 32'd0;
    taken       = 64'd0;
    len_limit   = wsdf_pkg::MaxPayloadReset;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    put_frame(OP_TEXT, 1'b1, 64'd2, 0, 1'b0);
    put_frame(wsdf_pkg::OP_BINARY, 1'b1, 64'd5, 0, 1'b1);
    put_frame(OP_CONT, 1'b0, 64'd0, 0, 1'b0);
    put_frame(wsdf_pkg::OP_PING, 1'b1, 64'd0, 0, 1'b1);
    put_frame(wsdf_pkg::OP_PING, 1'b1, 64'd1, 0, 1'b0);
    put_frame(OP_PONG, 1'b1, 64'd1, 0, 1'b1);
    put_frame(4'hF, 1'b0, 64'd0, 0, 1'b0);
    put_frame(OP_TEXT, 1'b0, 64'd3, 1, 1'b0);
    put_frame(OP_CONT, 1'b1, 64'd1, 2, 1'b1);
    set_limit(32'd0);
    put_frame(wsdf_pkg::OP_BINARY, 1'b1, 64'd0, 1, 1'b0);
    put_frame(wsdf_pkg::OP_PING, 1'b0, 64'd0, 2, 1'b1);
    set_limit(32'd3);
    put_frame(OP_TEXT, 1'b1, 64'd3, 2, 1'b1);

    while (bytes_queued < TargetBytes) begin
      r = $urandom_range(0, 4);
      case (r)
        0: set_limit(32'd0);
        1: set_limit($urandom_range(1, 30));
        2: set_limit(32'hFFFF_FFFF);
        3: set_limit(wsdf_pkg::MaxPayloadReset);
        default: set_limit($urandom);
      endcase
      repeat ($urandom_range(5, 20)) begin
        if (bytes_queued < TargetBytes) begin
          l = pick_len();
          put_frame(pick_op(), 1'($urandom), l, pick_form(l), ($urandom_range(0, 3) != 0));
        end
      end
    end

    // halt the parser, then show that further bytes are dropped
    if ($urandom_range(0, 1) == 0) begin
      l = 64'($urandom_range(0, 20));
      put_header(wsdf_pkg::OP_CLOSE, 1'($urandom), l, pick_form(l), 1'($urandom));
    end else begin
      set_limit(($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : $urandom_range(0, 200));
      if ($urandom_range(0, 1) == 0) l = 64'(len_limit) + 64'd1;
      else l = {32'($urandom_range(1, 32'hFFFF_FFFF)), 32'($urandom)};
      put_header(pick_op(), 1'($urandom), l, pick_form(l), 1'($urandom));
    end
    repeat (12) stream_q.push_back(8'($urandom));

    while (stream_q.size() != 0 || s_tvalid || owed_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fails == 0 && owed_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
